// ===== hdl/cwf_pkg.sv =====
// ----------------------------------------------------------------------------
// cwf_pkg
// Shared constants and types for the chassis command watchdog filter.
// ----------------------------------------------------------------------------
package cwf_pkg;

    localparam int WHEELS_DEFAULT = 4;
    localparam int WHEELS_MAX     = 4;

    localparam int SPEED_W = 16;
    localparam int LIMIT_W = 15;
    localparam int DECAY_W = 15;
    localparam int GAIN_W  = 17;
    localparam int QUAL_W  = 16;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 17;

    // quality score bounds, units of 1/256
    localparam logic [QUAL_W-1:0] Q_MAX   = 16'd25600;
    localparam logic [QUAL_W-1:0] Q_MIN   = 16'd1280;
    localparam logic [QUAL_W-1:0] Q_OFF   = 16'd7680;
    localparam logic [QUAL_W-1:0] Q_ON    = 16'd17920;
    localparam logic [QUAL_W-1:0] Q_BOOST = 16'd7680;

    localparam logic [GAIN_W-1:0] GAIN_ONE = 17'd65536;

    localparam logic [DECAY_W-1:0] DECAY_RST = 15'd1280;
    localparam logic [LIMIT_W-1:0] LIMIT_RST = 15'd32767;
    localparam logic [GAIN_W-1:0]  GAIN_RST  = 17'd32768;

    localparam logic [1:0] ACT_STOP  = 2'd0;
    localparam logic [1:0] ACT_DRIVE = 2'd1;
    localparam logic [1:0] ACT_HOLD  = 2'd2;

    localparam logic [1:0] LINK_OFFLINE = 2'd0;
    localparam logic [1:0] LINK_ONLINE  = 2'd1;
    localparam logic [1:0] LINK_BETWEEN = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_DECAY = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LIMIT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN  = 2'd2;

    typedef struct packed {
        logic               load;
        logic               clamp;
        logic               filt;
        logic [LIMIT_W-1:0] limit;
        logic [GAIN_W-1:0]  gain;
    } t_lane_ctl;

endpackage

// ===== hdl/cwf_if.sv =====
// ----------------------------------------------------------------------------
// cwf_if
// Valid/ready channels of the chassis command watchdog filter.
// ----------------------------------------------------------------------------
interface cwf_in_if;
    logic               valid;
    logic               ready;
    logic               cmd;
    logic signed [15:0] speed_a;
    logic signed [15:0] speed_b;
    logic signed [15:0] speed_c;
    logic signed [15:0] speed_d;
    logic               drop_alarm;

    modport source(output valid, cmd, speed_a, speed_b, speed_c, speed_d, drop_alarm,
                   input ready);
    modport sink(input valid, cmd, speed_a, speed_b, speed_c, speed_d, drop_alarm,
                 output ready);
endinterface

interface cwf_out_if;
    logic               valid;
    logic               ready;
    logic [1:0]         action;
    logic               over_speed;
    logic signed [15:0] drive_a;
    logic signed [15:0] drive_b;
    logic signed [15:0] drive_c;
    logic signed [15:0] drive_d;
    logic [15:0]        link_quality;
    logic [1:0]         link_state;

    modport source(output valid, action, over_speed, drive_a, drive_b, drive_c, drive_d,
                   link_quality, link_state, input ready);
    modport sink(input valid, action, over_speed, drive_a, drive_b, drive_c, drive_d,
                 link_quality, link_state, output ready);
endinterface

interface cwf_cfg_if;
    logic        valid;
    logic        ready;
    logic [1:0]  index;
    logic [16:0] data;

    modport source(output valid, index, data, input ready);
    modport sink(input valid, index, data, output ready);
endinterface

// ===== hdl/cwf_wheel.sv =====
// ----------------------------------------------------------------------------
// cwf_wheel
// One wheel lane: wanted speed store, limit clamp and first-order low-pass.
// ----------------------------------------------------------------------------
module cwf_wheel (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  cwf_pkg::t_lane_ctl          i_ctl,
    input  logic signed [15:0]          i_speed,
    output logic                        o_over,
    output logic signed [15:0]          o_drive
);
    import cwf_pkg::*;

    logic signed [SPEED_W-1:0] r_wanted, n_wanted;
    logic signed [SPEED_W-1:0] r_filt, n_filt;
    logic signed [16:0]        w_ext;
    logic signed [16:0]        lim_pos;
    logic signed [16:0]        lim_neg;
    logic signed [16:0]        clamped;
    logic signed [17:0]        diff;
    logic signed [35:0]        prod;
    logic signed [35:0]        rnd;
    logic signed [19:0]        step_sum;

    always_comb begin
        w_ext   = {r_wanted[SPEED_W-1], r_wanted};
        lim_pos = $signed({2'b00, i_ctl.limit});
        lim_neg = -lim_pos;
        o_over  = 1'b0;
        clamped = w_ext;
        if (w_ext > lim_pos) begin
            clamped = lim_pos;
            o_over  = i_ctl.clamp;
        end else if (w_ext < lim_neg) begin
            clamped = lim_neg;
            o_over  = i_ctl.clamp;
        end

        // f + floor((g*(w-f) + 32768) / 65536)
        diff     = {clamped[16], clamped} - {{2{r_filt[SPEED_W-1]}}, r_filt};
        prod     = $signed({1'b0, i_ctl.gain}) * diff;
        rnd      = prod + 36'sd32768;
        step_sum = rnd[35:16] + {{4{r_filt[SPEED_W-1]}}, r_filt};

        n_wanted = r_wanted;
        if (i_ctl.load) begin
            n_wanted = i_speed;
        end else if (i_ctl.clamp) begin
            n_wanted = clamped[SPEED_W-1:0];
        end

        n_filt  = i_ctl.filt ? step_sum[SPEED_W-1:0] : r_filt;
        o_drive = i_ctl.filt ? step_sum[SPEED_W-1:0] : '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wanted <= '0;
            r_filt   <= '0;
        end else begin
            r_wanted <= n_wanted;
            r_filt   <= n_filt;
        end
    end

endmodule

// ===== hdl/chassis_command_watchdog_filter.sv =====
// ----------------------------------------------------------------------------
// chassis_command_watchdog_filter
// Link watchdog and wheel speed low-pass for a chassis drive.
// ----------------------------------------------------------------------------
// Each item is taken into an input register and handled from there in
// one pass: a command loads the wanted speeds and raises the link
// quality, a tick decays the quality, sets the link state, clamps the speeds
// and runs one 17x18 multiply per wheel for the filter, all in parallel.
// One item is accepted every cycle unless the input stalls; a tick's result
// goes from the input register to the output register, a command gives no
// result. When the result register is full and not taken, a pending tick
// waits in the input register and the input stalls after that one item.
// ----------------------------------------------------------------------------
module chassis_command_watchdog_filter #(
    parameter int WHEELS = cwf_pkg::WHEELS_DEFAULT
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    cwf_in_if.sink    i_cmd,
    cwf_cfg_if.sink   i_cfg,
    cwf_out_if.source o_res
);
    import cwf_pkg::*;

    // configuration
    logic [DECAY_W-1:0] r_decay;
    logic [LIMIT_W-1:0] r_limit;
    logic [GAIN_W-1:0]  r_gain;

    // input register
    logic                      r_in_vld;
    logic                      r_tick;
    logic                      r_alarm;
    logic signed [SPEED_W-1:0] r_speed [WHEELS_MAX];

    // quality state
    logic [QUAL_W-1:0] r_qual, n_qual;

    // result register
    logic                      r_out_vld;
    logic [1:0]                r_action;
    logic                      r_over;
    logic signed [SPEED_W-1:0] r_drive [WHEELS_MAX];
    logic [QUAL_W-1:0]         r_oqual;
    logic [1:0]                r_olink;

    logic                      go;
    logic                      go_tick;
    logic [QUAL_W:0]           boost;
    logic signed [17:0]        decayed;
    logic [QUAL_W-1:0]         q_tick;
    logic [1:0]                link;
    logic [1:0]                action;
    logic [GAIN_W-1:0]         gain_sat;
    t_lane_ctl                 ctl;
    logic [WHEELS_MAX-1:0]     over_w;
    logic signed [SPEED_W-1:0] drive_w [WHEELS_MAX];

    assign go      = r_in_vld && (!r_tick || !r_out_vld || o_res.ready);
    assign go_tick = go && r_tick;

    assign i_cmd.ready = !r_in_vld || go;
    assign i_cfg.ready = 1'b1;

    always_comb begin
        boost   = {1'b0, r_qual} + {1'b0, Q_BOOST};
        decayed = $signed({2'b00, r_qual}) - $signed({3'b000, r_decay});
        if (decayed >= $signed({2'b00, Q_MAX})) begin
            q_tick = Q_MAX;
        end else if (decayed <= $signed({2'b00, Q_MIN})) begin
            q_tick = Q_MIN;
        end else begin
            q_tick = decayed[QUAL_W-1:0];
        end

        if (q_tick <= Q_OFF) begin
            link = LINK_OFFLINE;
        end else if (q_tick >= Q_ON) begin
            link = LINK_ONLINE;
        end else begin
            link = LINK_BETWEEN;
        end

        if (link == LINK_OFFLINE || r_alarm) begin
            action = ACT_STOP;
        end else if (link == LINK_ONLINE) begin
            action = ACT_DRIVE;
        end else begin
            action = ACT_HOLD;
        end

        n_qual = r_qual;
        if (go && !r_tick) begin
            n_qual = boost[QUAL_W] ? '1 : boost[QUAL_W-1:0];
        end else if (go_tick) begin
            n_qual = q_tick;
        end

        gain_sat  = (r_gain > GAIN_ONE) ? GAIN_ONE : r_gain;
        ctl.load  = go && !r_tick;
        ctl.clamp = go_tick;
        ctl.filt  = go_tick && (action == ACT_DRIVE);
        ctl.limit = r_limit;
        ctl.gain  = gain_sat;
    end

    for (genvar i = 0; i < WHEELS_MAX; i++) begin : g_wheel
        if (i < WHEELS) begin : g_on
            cwf_wheel u_wheel (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_ctl   (ctl),
                .i_speed (r_speed[i]),
                .o_over  (over_w[i]),
                .o_drive (drive_w[i])
            );
        end else begin : g_off
            assign over_w[i]  = 1'b0;
            assign drive_w[i] = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_decay   <= DECAY_RST;
            r_limit   <= LIMIT_RST;
            r_gain    <= GAIN_RST;
            r_in_vld  <= 1'b0;
            r_out_vld <= 1'b0;
            r_qual    <= '0;
        end else begin
            if (i_cfg.valid) begin
                case (i_cfg.index)
                    REG_DECAY: r_decay <= i_cfg.data[DECAY_W-1:0];
                    REG_LIMIT: r_limit <= i_cfg.data[LIMIT_W-1:0];
                    REG_GAIN:  r_gain  <= i_cfg.data[GAIN_W-1:0];
                    default:   ;
                endcase
            end
            if (i_cmd.valid && i_cmd.ready) begin
                r_in_vld <= 1'b1;
            end else if (go) begin
                r_in_vld <= 1'b0;
            end
            if (go_tick) begin
                r_out_vld <= 1'b1;
            end else if (o_res.ready) begin
                r_out_vld <= 1'b0;
            end
            r_qual <= n_qual;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.valid && i_cmd.ready) begin
            r_tick     <= i_cmd.cmd;
            r_alarm    <= i_cmd.drop_alarm;
            r_speed[0] <= i_cmd.speed_a;
            r_speed[1] <= i_cmd.speed_b;
            r_speed[2] <= i_cmd.speed_c;
            r_speed[3] <= i_cmd.speed_d;
        end
        if (go_tick) begin
            r_action <= action;
            r_over   <= |over_w;
            r_oqual  <= q_tick;
            r_olink  <= link;
            for (int k = 0; k < WHEELS_MAX; k++) begin
                r_drive[k] <= drive_w[k];
            end
        end
    end

    assign o_res.valid        = r_out_vld;
    assign o_res.action       = r_action;
    assign o_res.over_speed   = r_over;
    assign o_res.drive_a      = r_drive[0];
    assign o_res.drive_b      = r_drive[1];
    assign o_res.drive_c      = r_drive[2];
    assign o_res.drive_d      = r_drive[3];
    assign o_res.link_quality = r_oqual;
    assign o_res.link_state   = r_olink;

endmodule

// ===== hdl/cwf_checker.sv =====
// ----------------------------------------------------------------------------
// cwf_checker
// Port-level checks on the results of the chassis command watchdog filter.
// ----------------------------------------------------------------------------
module cwf_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_valid,
    input logic               i_ready,
    input logic [1:0]         i_action,
    input logic signed [15:0] i_drive_a,
    input logic signed [15:0] i_drive_b,
    input logic signed [15:0] i_drive_c,
    input logic signed [15:0] i_drive_d,
    input logic [15:0]        i_link_quality,
    input logic [1:0]         i_link_state
);
    import cwf_pkg::*;

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !i_ready |=> i_valid && $stable(i_link_quality) && $stable(i_action))
        else $error("result changed while stalled");

    a_qual_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid |-> i_link_quality >= Q_MIN && i_link_quality <= Q_MAX)
        else $error("link quality out of range");

    a_drive_online: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && i_action == ACT_DRIVE |-> i_link_state == LINK_ONLINE)
        else $error("drive issued while not online");

    a_offline_stop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && i_link_state == LINK_OFFLINE |-> i_action == ACT_STOP)
        else $error("offline without stop");

    a_idle_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && i_action != ACT_DRIVE |->
            i_drive_a == 16'sd0 && i_drive_b == 16'sd0 &&
            i_drive_c == 16'sd0 && i_drive_d == 16'sd0)
        else $error("nonzero drive without drive action");

endmodule

bind chassis_command_watchdog_filter cwf_checker u_cwf_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_valid        (o_res.valid),
    .i_ready        (o_res.ready),
    .i_action       (o_res.action),
    .i_drive_a      (o_res.drive_a),
    .i_drive_b      (o_res.drive_b),
    .i_drive_c      (o_res.drive_c),
    .i_drive_d      (o_res.drive_d),
    .i_link_quality (o_res.link_quality),
    .i_link_state   (o_res.link_state)
);

// ===== tb/cwf_result_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// cwf_result_checker
// Watches the command, register and result channels of the chassis command
// watchdog filter, tracks link quality, wanted and filtered wheel speeds and
// the active register values, and compares every result transfer, field by
// field, with the oldest tick outcome still due.
// ----------------------------------------------------------------------------
module cwf_result_checker (
    input  logic i_clk,
    input  logic i_rst_n,
    cwf_in_if    i_cmd,
    cwf_cfg_if   i_cfg,
    cwf_out_if   i_res,
    output int   o_fail_count,
    output int   o_pending,
    output int   o_checked,
    output int   o_stops,
    output int   o_drives,
    output int   o_holds
);
    import cwf_pkg::*;

    localparam logic ITEM_TICK = 1'b1;

    typedef struct packed {
        logic [1:0]                   action;
        logic                         over_speed;
        logic [3:0][SPEED_W-1:0]      drive;
        logic [QUAL_W-1:0]            link_quality;
        logic [1:0]                   link_state;
    } t_tick_outcome;

    t_tick_outcome due_outcomes[$];

    logic [DECAY_W-1:0]        decay_now;
    logic [LIMIT_W-1:0]        limit_now;
    logic [GAIN_W-1:0]         gain_now;
    logic signed [SPEED_W-1:0] wanted [WHEELS_MAX];
    logic signed [SPEED_W-1:0] filtered [WHEELS_MAX];
    logic [QUAL_W-1:0]         quality;
    logic [1:0]                link;

    string wheel_tag [WHEELS_MAX] = '{"a", "b", "c", "d"};

    task automatic report_mismatch(string msg);
        $display("[%0t] mismatch: %s", $realtime, msg);
        o_fail_count++;
    endtask

    always @(posedge i_clk) begin
        t_tick_outcome got;
        t_tick_outcome want;
        int q;
        int lim;
        longint acc;
        logic [GAIN_W-1:0] g;
        if (!i_rst_n) begin
            decay_now = DECAY_RST;
            limit_now = LIMIT_RST;
            gain_now  = GAIN_RST;
            for (int w = 0; w < WHEELS_MAX; w++) begin
                wanted[w]   = '0;
                filtered[w] = '0;
            end
            quality = '0;
            link    = LINK_OFFLINE;
            due_outcomes.delete();
            o_fail_count = 0;
            o_checked    = 0;
            o_stops      = 0;
            o_drives     = 0;
            o_holds      = 0;
        end else begin
            // result first: a tick accepted at this edge cannot be its source
            if (i_res.valid && i_res.ready) begin
                got.action       = i_res.action;
                got.over_speed   = i_res.over_speed;
                got.drive[0]     = i_res.drive_a;
                got.drive[1]     = i_res.drive_b;
                got.drive[2]     = i_res.drive_c;
                got.drive[3]     = i_res.drive_d;
                got.link_quality = i_res.link_quality;
                got.link_state   = i_res.link_state;
                if (due_outcomes.size() == 0) begin
                    report_mismatch($sformatf("result transfer with no tick waiting (action %0d)",
                                              got.action));
                end else begin
                    want = due_outcomes.pop_front();
                    if (got.action !== want.action)
                        report_mismatch($sformatf("result %0d action %0d, expected %0d",
                                                  o_checked, got.action, want.action));
                    if (got.over_speed !== want.over_speed)
                        report_mismatch($sformatf("result %0d over_speed %0d, expected %0d",
                                                  o_checked, got.over_speed, want.over_speed));
                    for (int w = 0; w < WHEELS_MAX; w++) begin
                        if (got.drive[w] !== want.drive[w])
                            report_mismatch($sformatf("result %0d drive_%s %0d, expected %0d",
                                                      o_checked, wheel_tag[w],
                                                      $signed(got.drive[w]),
                                                      $signed(want.drive[w])));
                    end
                    if (got.link_quality !== want.link_quality)
                        report_mismatch($sformatf("result %0d link_quality %0d, expected %0d",
                                                  o_checked, got.link_quality,
                                                  want.link_quality));
                    if (got.link_state !== want.link_state)
                        report_mismatch($sformatf("result %0d link_state %0d, expected %0d",
                                                  o_checked, got.link_state, want.link_state));
                    case (want.action)
                        ACT_STOP:  o_stops++;
                        ACT_DRIVE: o_drives++;
                        default:   o_holds++;
                    endcase
                    o_checked++;
                end
            end

            if (i_cfg.valid && i_cfg.ready) begin
                case (i_cfg.index)
                    REG_DECAY: decay_now = i_cfg.data[DECAY_W-1:0];
                    REG_LIMIT: limit_now = i_cfg.data[LIMIT_W-1:0];
                    REG_GAIN:  gain_now  = i_cfg.data;
                    default:   ;
                endcase
            end

            if (i_cmd.valid && i_cmd.ready) begin
                if (i_cmd.cmd != ITEM_TICK) begin
                    wanted[0] = i_cmd.speed_a;
                    wanted[1] = i_cmd.speed_b;
                    wanted[2] = i_cmd.speed_c;
                    wanted[3] = i_cmd.speed_d;
                    q = int'(quality) + int'(Q_BOOST);
                    if (q > 65535)
                        q = 65535;
                    quality = q[QUAL_W-1:0];
                end else begin
                    want = '0;
                    q = int'(quality) - int'(decay_now);
                    if (q >= int'(Q_MAX))
                        q = int'(Q_MAX);
                    else if (q <= int'(Q_MIN))
                        q = int'(Q_MIN);
                    quality = q[QUAL_W-1:0];
                    if (q <= int'(Q_OFF))
                        link = LINK_OFFLINE;
                    else if (q >= int'(Q_ON))
                        link = LINK_ONLINE;
                    else
                        link = LINK_BETWEEN;

                    lim = int'(limit_now);
                    for (int w = 0; w < WHEELS_MAX; w++) begin
                        if (int'(wanted[w]) > lim) begin
                            wanted[w] = lim[SPEED_W-1:0];
                            want.over_speed = 1'b1;
                        end else if (int'(wanted[w]) < -lim) begin
                            q = -lim;
                            wanted[w] = q[SPEED_W-1:0];
                            want.over_speed = 1'b1;
                        end
                    end

                    if (link == LINK_OFFLINE || i_cmd.drop_alarm) begin
                        want.action = ACT_STOP;
                    end else if (link == LINK_ONLINE) begin
                        want.action = ACT_DRIVE;
                        g = (gain_now > GAIN_ONE) ? GAIN_ONE : gain_now;
                        for (int w = 0; w < WHEELS_MAX; w++) begin
                            acc = (longint'(GAIN_ONE) - longint'(g)) * longint'(filtered[w])
                                + longint'(g) * longint'(wanted[w]) + 64'sd32768;
                            acc = acc >>> 16;
                            filtered[w]   = acc[SPEED_W-1:0];
                            want.drive[w] = acc[SPEED_W-1:0];
                        end
                    end else begin
                        want.action = ACT_HOLD;
                    end
                    want.link_quality = quality;
                    want.link_state   = link;
                    due_outcomes.push_back(want);
                end
            end
        end
        o_pending = due_outcomes.size();
    end

endmodule

// ===== tb/tb_chassis_command_watchdog_filter.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_chassis_command_watchdog_filter
// Drives speed commands, control ticks and register writes into the chassis
// command watchdog filter: a directed walk through the link states first,
// then phases of random traffic under changing register settings, with
// random gaps on the command side and random stalls on the result side.
// ----------------------------------------------------------------------------
module tb_chassis_command_watchdog_filter;
    import cwf_pkg::*;

    localparam logic ITEM_SPEED = 1'b0;
    localparam logic ITEM_TICK  = 1'b1;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;

    localparam int STALL_LIMIT   = 2000;
    localparam int SETTLE_CYCLES = 4;
    localparam int PHASES        = 10;
    localparam int PHASE_ITEMS   = 123;

    logic clk;
    logic rst_n;
    int   gap_mode;
    int   fail_count, pending, checked, stops, drives, holds;
    int   n_items, n_ticks, n_writes, n_settings;
    logic [LIMIT_W-1:0] limit_cur;

    cwf_in_if  cmd_ch ();
    cwf_cfg_if cfg_ch ();
    cwf_out_if res_ch ();

    chassis_command_watchdog_filter dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_cmd   (cmd_ch),
        .i_cfg   (cfg_ch),
        .o_res   (res_ch)
    );

    cwf_result_checker u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_cmd        (cmd_ch),
        .i_cfg        (cfg_ch),
        .i_res        (res_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_checked    (checked),
        .o_stops      (stops),
        .o_drives     (drives),
        .o_holds      (holds)
    );

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // mostly short gaps, a few long ones; none while gap_mode is zero
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (gap_mode == 0)
            return 0;
        if (r < 60)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        if (r < 98)
            return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [SPEED_W-1:0] rand_speed();
        int r;
        int v;
        r = $urandom_range(0, 9);
        case (r)
            0: v = 32767;
            1: v = -32768;
            2: v = int'($urandom_range(0, 512)) - 256;
            3: begin
                v = int'(limit_cur) + int'($urandom_range(0, 4)) - 2;
                if ($urandom_range(0, 1))
                    v = -v;
            end
            default: v = int'($urandom);
        endcase
        return v[SPEED_W-1:0];
    endfunction

    initial begin
        int stall;
        res_ch.ready = 1'b0;
        stall = 0;
        forever begin
            @(negedge clk);
            if (stall > 0) begin
                res_ch.ready <= 1'b0;
                stall--;
            end else begin
                res_ch.ready <= 1'b1;
                stall = pick_gap();
            end
        end
    end

    initial begin
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(posedge clk);
            if ((cmd_ch.valid && cmd_ch.ready) || (cfg_ch.valid && cfg_ch.ready) ||
                (res_ch.valid && res_ch.ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("watchdog: no transfer for %0d cycles", STALL_LIMIT);
        $display("FAILURE");
        $finish;
    end

    task automatic send_item(logic kind, logic [SPEED_W-1:0] a, logic [SPEED_W-1:0] b,
                             logic [SPEED_W-1:0] c, logic [SPEED_W-1:0] d, logic drop);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            cmd_ch.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        cmd_ch.valid      <= 1'b1;
        cmd_ch.cmd        <= kind;
        cmd_ch.speed_a    <= a;
        cmd_ch.speed_b    <= b;
        cmd_ch.speed_c    <= c;
        cmd_ch.speed_d    <= d;
        cmd_ch.drop_alarm <= drop;
        @(posedge clk);
        while (!cmd_ch.ready) @(posedge clk);
        @(negedge clk);
        n_items++;
        if (kind == ITEM_TICK)
            n_ticks++;
    endtask

    task automatic send_random(int p_cmd);
        if ($urandom_range(0, 99) < p_cmd)
            send_item(ITEM_SPEED, rand_speed(), rand_speed(), rand_speed(), rand_speed(),
                      1'($urandom));
        else
            send_item(ITEM_TICK, 16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                      $urandom_range(0, 99) < 15);
    endtask

    task automatic wait_idle();
        cmd_ch.valid <= 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // caller lowers cfg_ch.valid after the last write of a batch
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] value);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= value;
        @(posedge clk);
        while (!cfg_ch.ready) @(posedge clk);
        @(negedge clk);
        n_writes++;
    endtask

    task automatic apply_settings(logic [DECAY_W-1:0] decay, logic [LIMIT_W-1:0] limit,
                                  logic [GAIN_W-1:0] gain, logic spare);
        wait_idle();
        write_reg(REG_DECAY, {2'($urandom), decay});
        write_reg(REG_LIMIT, {2'($urandom), limit});
        write_reg(REG_GAIN, gain);
        if (spare)
            write_reg(REG_SPARE, 17'($urandom));
        cfg_ch.valid <= 1'b0;
        limit_cur = limit;
        n_settings++;
    endtask

    initial begin
        logic [DECAY_W-1:0] decay;
        logic [LIMIT_W-1:0] limit;
        logic [GAIN_W-1:0]  gain;
        int p_cmd;
        rst_n             = 1'b0;
        cmd_ch.valid      = 1'b0;
        cmd_ch.cmd        = ITEM_SPEED;
        cmd_ch.speed_a    = '0;
        cmd_ch.speed_b    = '0;
        cmd_ch.speed_c    = '0;
        cmd_ch.speed_d    = '0;
        cmd_ch.drop_alarm = 1'b0;
        cfg_ch.valid      = 1'b0;
        cfg_ch.index      = REG_DECAY;
        cfg_ch.data       = '0;
        gap_mode          = 1;
        limit_cur         = LIMIT_RST;
        n_items           = 0;
        n_ticks           = 0;
        n_writes          = 0;
        n_settings        = 0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed walk at reset settings
        send_item(ITEM_TICK, 16'h7fff, 16'h8000, 16'h1234, 16'hffff, 1'b0);  // decay past zero
        send_item(ITEM_SPEED, 16'h7fff, 16'h8000, 16'h0000, 16'hffff, 1'b1); // alarm ignored
        send_item(ITEM_TICK, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b0);  // offline edge
        repeat (9)
            send_item(ITEM_SPEED, 16'h8000, 16'h7fff, 16'h0100, 16'hff00, 1'b0); // saturate
        send_item(ITEM_TICK, 16'hffff, 16'hffff, 16'hffff, 16'hffff, 1'b0);
        send_item(ITEM_TICK, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b1);  // alarm online
        repeat (5)
            send_item(ITEM_TICK, 16'h5555, 16'haaaa, 16'h0000, 16'hffff, 1'b0); // to online edge
        send_item(ITEM_TICK, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b0);  // hold
        send_item(ITEM_TICK, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b1);  // alarm in hold

        for (int k = 0; k < PHASES; k++) begin
            case (k)
                0: begin decay = DECAY_RST; limit = LIMIT_RST; gain = GAIN_RST; end
                1: begin decay = 15'd0;     limit = 15'd0;     gain = 17'd0;    end
                2: begin decay = Q_MAX[DECAY_W-1:0]; limit = LIMIT_RST; gain = GAIN_ONE; end
                3: begin decay = 15'h7fff;  limit = 15'd1;     gain = 17'h1ffff; end
                4: begin decay = 15'd1;     limit = 15'd100;   gain = 17'd1;    end
                default: begin
                    decay = 15'($urandom_range(0, 25600));
                    limit = 15'($urandom);
                    if ($urandom_range(0, 9) < 7)
                        gain = 17'($urandom_range(0, 65536));
                    else
                        gain = 17'($urandom);
                end
            endcase
            apply_settings(decay, limit, gain, k == 5);
            gap_mode = (k % 3 == 1) ? 0 : 1;
            case ($urandom_range(0, 3))
                0: p_cmd = 15;
                1: p_cmd = 30;
                2: p_cmd = 45;
                default: p_cmd = 70;
            endcase
            repeat (PHASE_ITEMS)
                send_random(p_cmd);
        end

        gap_mode = 1;
        wait_idle();
        $display("covered %0d items (%0d ticks) under %0d register settings, %0d writes",
                 n_items, n_ticks, n_settings, n_writes);
        $display("compared %0d results: %0d stop, %0d drive, %0d hold",
                 checked, stops, drives, holds);
        if (fail_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
